/* design/ptts_pkg.sv */
// shared types and codes for the periodic task table scheduler
// no dependencies; imported by every module of the block
package ptts_pkg;

   // request modes
   localparam logic [1:0] MODE_ADD      = 2'd0;
   localparam logic [1:0] MODE_REMOVE   = 2'd1;
   localparam logic [1:0] MODE_TICK     = 2'd2;
   localparam logic [1:0] MODE_DISPATCH = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DUP       = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // most tasks emitted by one dispatch
   localparam int RESULT_CAP_W = 4;
   localparam logic [RESULT_CAP_W-1:0] RESULT_CAP = 4'd8;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] task_key;
      logic [31:0] task_param;
      logic [15:0] period;
      logic [15:0] initial_expire;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        has_task;
      logic [15:0] out_key;
      logic [31:0] out_param;
      logic        last;
   } rsp_type;

   // one table slot
   typedef struct packed {
      logic [15:0] key;
      logic [31:0] param;
      logic [15:0] period;
      logic [15:0] countdown;
      logic        pending;
   } entry_type;

   // what the slot unit reports on the slot just read
   typedef struct packed {
      logic      match;
      logic      pending;
      logic      one_shot;
      entry_type ticked;
      entry_type cleared;
   } slot_eval_type;

endpackage

/* design/periodic_task_table_scheduler.sv */
// top level of the periodic task table scheduler: sequencer, table and slot unit
// depends on ptts_pkg, ptts_table and ptts_slot_unit
//
// An item is taken when start is high and busy is low; busy then stays high
// until the item's last result beat has been registered. Results come out on
// rsp_strobe, one beat per strobe, and cannot be held off, so the receiver must
// take every beat in the cycle it appears; rsp_data.last marks the final beat of
// an item. The table is one memory with a single read port and registered read
// data, walked by a small sequencer through one shared slot unit: each slot
// visited takes a read state and an evaluate state. A duplicate add stops at
// the matching slot, a found remove moves every later slot down by one to close
// the gap, and either walks all entries when the key is absent. Tick walks all
// entries. Dispatch walks all entries unless it stops early after eight tasks,
// and moves later slots down for each one-shot task that leaves the table. At
// most eight tasks go out per dispatch; later pending tasks wait for the next
// one. No clearing pass is needed after reset.
module periodic_task_table_scheduler import ptts_pkg::*; #(
   parameter int MAX_TASKS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_SHIFT,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

   // sequencer control
   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   rsp_type     rsp_ff, rsp_in;

   // walk state and captured request
   req_type     req_ff, req_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] j_ff, j_in;
   logic [RESULT_CAP_W-1:0] n_ff, n_in;
   logic        held_valid_ff, held_valid_in;
   logic [15:0] held_key_ff, held_key_in;
   logic [31:0] held_param_ff, held_param_in;
   logic [1:0]  status_ff, status_in;

   // table ports
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;
   logic [IW-1:0] rd_addr;
   entry_type     rd_data;

   slot_eval_type eval;
   entry_type     new_entry;
   logic [CW-1:0] idx_plus;
   logic [CW-1:0] j_plus;

   ptts_table #(
      .DEPTH (MAX_TASKS),
      .IW    (IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ptts_slot_unit u_slot_unit (
      .entry (rd_data),
      .key   (req_ff.task_key),
      .eval  (eval)
   );

   assign idx_plus = idx_ff + 1'b1;
   assign j_plus   = j_ff + 1'b1;

   // added entry starts not pending
   always_comb begin
      new_entry.key       = req_ff.task_key;
      new_entry.param     = req_ff.task_param;
      new_entry.period    = req_ff.period;
      new_entry.countdown = req_ff.initial_expire;
      new_entry.pending   = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      held_valid_in = held_valid_ff;
      held_key_in   = held_key_ff;
      held_param_in = held_param_ff;
      status_in     = status_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IW-1:0];
      wr_data       = eval.ticked;
      rd_addr       = idx_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in        = req_data;
               idx_in        = '0;
               n_in          = '0;
               held_valid_in = 1'b0;
               status_in     = ST_OK;
               state_in      = S_READ;
            end
         end

         // issue the read of slot idx, or wrap up once the walk is done
         S_READ: begin
            if ((idx_ff < count_ff) &&
                ((req_ff.mode != MODE_DISPATCH) || (n_ff < RESULT_CAP))) begin
               state_in = S_EVAL;
            end else begin
               state_in = S_FINISH;
               case (req_ff.mode)
                  MODE_ADD: begin
                     if (count_ff == CW'(MAX_TASKS)) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IW-1:0];
                        wr_data  = new_entry;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_REMOVE: begin
                     status_in = ST_NOT_FOUND;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // slot idx is on rd_data now
         S_EVAL: begin
            state_in = S_READ;
            idx_in   = idx_plus;
            case (req_ff.mode)
               MODE_ADD: begin
                  if (eval.match) begin
                     status_in = ST_DUP;
                     state_in  = S_FINISH;
                  end
               end
               MODE_REMOVE: begin
                  if (eval.match) begin
                     idx_in   = idx_ff;
                     j_in     = idx_ff;
                     state_in = S_SHIFT;
                  end
               end
               MODE_TICK: begin
                  wr_en   = 1'b1;
                  wr_data = eval.ticked;
               end
               MODE_DISPATCH: begin
                  if (eval.pending) begin
                     // the held task is not the last one: send it now
                     if (held_valid_ff) begin
                        rsp_strobe_in    = 1'b1;
                        rsp_in.status    = ST_OK;
                        rsp_in.has_task  = 1'b1;
                        rsp_in.out_key   = held_key_ff;
                        rsp_in.out_param = held_param_ff;
                        rsp_in.last      = 1'b0;
                     end
                     held_valid_in = 1'b1;
                     held_key_in   = rd_data.key;
                     held_param_in = rd_data.param;
                     n_in          = n_ff + 1'b1;
                     if (eval.one_shot) begin
                        // one-shot leaves the table, revisit the same slot after
                        idx_in   = idx_ff;
                        j_in     = idx_ff;
                        state_in = S_SHIFT;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = eval.cleared;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         // close the gap at slot j: S_SHIFT reads the next slot, S_SHIFT_WR writes it one down
         S_SHIFT: begin
            if (j_plus < count_ff) begin
               rd_addr  = j_plus[IW-1:0];
               state_in = S_SHIFT_WR;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = (req_ff.mode == MODE_REMOVE) ? S_FINISH : S_READ;
            end
         end

         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[IW-1:0];
            wr_data  = rd_data;
            j_in     = j_plus;
            state_in = S_SHIFT;
         end

         // final beat: the held task, or a plain status
         S_FINISH: begin
            rsp_strobe_in    = 1'b1;
            rsp_in.status    = status_ff;
            rsp_in.has_task  = held_valid_ff;
            rsp_in.out_key   = held_valid_ff ? held_key_ff : 16'd0;
            rsp_in.out_param = held_valid_ff ? held_param_ff : 32'd0;
            rsp_in.last      = 1'b1;
            state_in         = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_ff        <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      j_ff          <= j_in;
      n_ff          <= n_in;
      held_valid_ff <= held_valid_in;
      held_key_ff   <= held_key_in;
      held_param_ff <= held_param_in;
      status_ff     <= status_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* design/ptts_table.sv */
// entry table: one write port, one read port with registered read data
// depends on ptts_pkg for the entry record type
module ptts_table import ptts_pkg::*; #(
   parameter int DEPTH = 8,
   parameter int IW    = 3
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [IW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ptts_slot_unit.sv */
// shared slot unit: key compare, countdown step and pending clear on one entry
// depends on ptts_pkg for the entry and result record types
module ptts_slot_unit import ptts_pkg::*; (
   input  entry_type     entry,
   input  logic [15:0]   key,
   output slot_eval_type eval
);

   logic [15:0] cd_dec;

   always_comb begin
      cd_dec = (entry.countdown != 16'd0) ? (entry.countdown - 16'd1) : 16'd0;

      eval.match    = (entry.key == key);
      eval.pending  = entry.pending;
      eval.one_shot = (entry.period == 16'd0);

      // countdown reaching zero reloads and marks the slot pending
      eval.ticked = entry;
      if (cd_dec == 16'd0) begin
         eval.ticked.countdown = entry.period;
         eval.ticked.pending   = 1'b1;
      end else begin
         eval.ticked.countdown = cd_dec;
      end

      eval.cleared         = entry;
      eval.cleared.pending = 1'b0;
   end

endmodule

/* design/ptts_checker.sv */
// port-level checks for the periodic task table scheduler, bound to the top level
// depends on ptts_pkg and periodic_task_table_scheduler
module ptts_checker import ptts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // an accepted item raises busy in the cycle after it is taken
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted without going busy");

   // a beat without a task is always the only and final beat
   a_no_task_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.has_task) |-> rsp_data.last)
      else $error("status-only beat not marked last");

   // status-only beats carry zero task fields
   a_no_task_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.has_task) |->
      (rsp_data.out_key == 16'd0 && rsp_data.out_param == 32'd0))
      else $error("status-only beat carries task fields");

   // dispatched tasks always report ok
   a_task_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.has_task) |-> (rsp_data.status == ST_OK))
      else $error("dispatched task with error status");

   // the block cannot produce a beat right after an item's final beat
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |=> !rsp_strobe)
      else $error("beat directly after a final beat");

endmodule

bind periodic_task_table_scheduler ptts_checker u_ptts_checker (.*);
